### hdl/dspv_pkg.sv
// shared types, constants and helpers for the date string parser
package dspv_pkg;

    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int YEAR_W      = 12;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int ACC_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int ORDER_W     = 2;
    localparam int NUM_FIELDS  = 3;
    localparam int FIELD_IDX_W = 2;
    localparam int DIGIT_W     = 4;
    localparam int KIND_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_SEP   = 2'd1;

    // field order codes
    localparam logic [ORDER_W-1:0] ORDER_MDY = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_DMY = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_YMD = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_VALID  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // character classes
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_END   = 2'd0;
    localparam kind_t KIND_DIGIT = 2'd1;
    localparam kind_t KIND_SEP   = 2'd2;
    localparam kind_t KIND_OTHER = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SLASH      = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_DASH       = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] EXTRA_SEP_RESET = 8'd46;

    localparam logic [ACC_W-1:0] YEAR_MIN      = 16'd1980;
    localparam logic [ACC_W-1:0] YEAR_MAX      = 16'd2099;
    localparam logic [ACC_W-1:0] SHORT_MAX     = 16'd99;
    localparam logic [ACC_W-1:0] SHORT_PIVOT   = 16'd80;
    localparam logic [ACC_W-1:0] CENTURY_1900  = 16'd1900;
    localparam logic [ACC_W-1:0] CENTURY_2000  = 16'd2000;
    localparam logic [ACC_W-1:0] MONTH_MAX     = 16'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [DAY_W-1:0] FEB_LEAP_DAYS = 5'd29;

    typedef struct packed {
        kind_t                kind;
        logic [DIGIT_W-1:0]   digit;
    } token_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // days in a month, common year
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### hdl/dspv_if.sv
// channel interfaces: character items in, date result items out

interface dspv_char_if;
    import dspv_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface dspv_date_if;
    import dspv_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;

    modport source (output valid, output status, output year, output month, output day,
                    input ready);
    modport sink   (input valid, input status, input year, input month, input day,
                    output ready);
endinterface

### hdl/dspv_front.sv
// front end: accepts characters and classifies them into tokens
module dspv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  dspv_pkg::cfg_write_t cfg,
    dspv_char_if.sink           chars,
    output logic                push_valid,
    output dspv_pkg::token_t    push_tok,
    input  logic                push_ready
);
    import dspv_pkg::*;

    logic [CHAR_W-1:0] extra_sep_reg;
    logic [CHAR_W-1:0] extra_sep_next;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] c_off;

    always_comb
    begin
        extra_sep_next = extra_sep_reg;
        if (cfg.we && cfg.index == REG_EXTRA_SEP)
        begin
            extra_sep_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_sep_reg <= EXTRA_SEP_RESET;
        end
        else
        begin
            extra_sep_reg <= extra_sep_next;
        end
    end

    assign c     = chars.character;
    assign c_off = c - CHAR_ZERO;

    // end of string wins, then digits, then separators
    always_comb
    begin
        push_tok.digit = c_off[DIGIT_W-1:0];
        if (c == CHAR_NUL)
        begin
            push_tok.kind = KIND_END;
        end
        else if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            push_tok.kind = KIND_DIGIT;
        end
        else if (c == CHAR_SLASH || c == CHAR_DASH || c == extra_sep_reg)
        begin
            push_tok.kind = KIND_SEP;
        end
        else
        begin
            push_tok.kind = KIND_OTHER;
        end
    end

    assign push_valid  = chars.valid;
    assign chars.ready = push_ready;

endmodule

### hdl/dspv_queue.sv
// short token queue between front and back
module dspv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  dspv_pkg::token_t push_tok,
    output logic             push_ready,
    output logic             pop_valid,
    output dspv_pkg::token_t pop_tok,
    input  logic             pop_ready
);
    import dspv_pkg::*;

    token_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        logic [QUEUE_PTR_W-1:0] r;
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

### hdl/dspv_back.sv
// back end: parse state, number accumulation, date check and result register
module dspv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dspv_pkg::cfg_write_t cfg,
    input  logic                 tok_valid,
    input  dspv_pkg::token_t     tok,
    output logic                 tok_ready,
    dspv_date_if.source          dates
);
    import dspv_pkg::*;

    logic [ORDER_W-1:0]     order_reg;
    logic [ORDER_W-1:0]     order_next;
    logic [FIELD_IDX_W-1:0] field_idx_reg;
    logic [FIELD_IDX_W-1:0] field_idx_next;
    logic                   digits_seen_reg;
    logic                   digits_seen_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   failed_reg;
    logic                   failed_next;
    logic                   any_seen_reg;
    logic                   any_seen_next;
    logic [ACC_W-1:0]       acc_reg  [NUM_FIELDS];
    logic [ACC_W-1:0]       acc_next [NUM_FIELDS];

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [YEAR_W-1:0]      out_year_reg;
    logic [MONTH_W-1:0]     out_month_reg;
    logic [DAY_W-1:0]       out_day_reg;

    logic                   out_free;
    logic                   take;
    logic                   is_end;
    logic                   active;

    logic [ACC_W-1:0]       y_raw;
    logic [ACC_W-1:0]       m_raw;
    logic [ACC_W-1:0]       d_raw;
    logic [ACC_W-1:0]       y_exp;
    logic [DAY_W-1:0]       day_lim;
    logic                   range_ok;
    logic                   complete;
    logic [STATUS_W-1:0]    fin_status;

    assign out_free  = !out_valid_reg || dates.ready;
    assign is_end    = (tok.kind == KIND_END);
    assign tok_ready = !is_end || out_free;
    assign take      = tok_valid && tok_ready;
    assign active    = !failed_reg && !done_reg;

    // configuration
    always_comb
    begin
        order_next = order_reg;
        if (cfg.we && cfg.index == REG_FIELD_ORDER)
        begin
            order_next = cfg.data[ORDER_W-1:0];
        end
    end

    // parse state
    always_comb
    begin
        field_idx_next   = field_idx_reg;
        digits_seen_next = digits_seen_reg;
        done_next        = done_reg;
        failed_next      = failed_reg;
        any_seen_next    = any_seen_reg;
        if (take)
        begin
            if (is_end)
            begin
                field_idx_next   = '0;
                digits_seen_next = 1'b0;
                done_next        = 1'b0;
                failed_next      = 1'b0;
                any_seen_next    = 1'b0;
            end
            else
            begin
                any_seen_next = 1'b1;
                if (active)
                begin
                    if (tok.kind == KIND_DIGIT)
                    begin
                        digits_seen_next = 1'b1;
                    end
                    else if (!digits_seen_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (field_idx_reg == FIELD_IDX_W'(NUM_FIELDS - 1))
                    begin
                        done_next = 1'b1;
                    end
                    else if (tok.kind == KIND_SEP)
                    begin
                        field_idx_next   = field_idx_reg + 1'b1;
                        digits_seen_next = 1'b0;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
    end

    // one accumulator lane per number, each times ten plus digit
    always_comb
    begin
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            acc_next[k] = acc_reg[k];
            if (take && is_end)
            begin
                acc_next[k] = '0;
            end
            else if (take && active && tok.kind == KIND_DIGIT
                     && field_idx_reg == FIELD_IDX_W'(k))
            begin
                acc_next[k] = (acc_reg[k] << 3) + (acc_reg[k] << 1)
                              + ACC_W'(tok.digit);
            end
        end
    end

    // final check
    always_comb
    begin
        case (order_reg)
            ORDER_DMY:
            begin
                d_raw = acc_reg[0];
                m_raw = acc_reg[1];
                y_raw = acc_reg[2];
            end
            ORDER_YMD:
            begin
                y_raw = acc_reg[0];
                m_raw = acc_reg[1];
                d_raw = acc_reg[2];
            end
            default:
            begin
                m_raw = acc_reg[0];
                d_raw = acc_reg[1];
                y_raw = acc_reg[2];
            end
        endcase

        if (y_raw <= SHORT_MAX)
        begin
            y_exp = y_raw + ((y_raw >= SHORT_PIVOT) ? CENTURY_1900 : CENTURY_2000);
        end
        else
        begin
            y_exp = y_raw;
        end

        // within 1980-2099 a leap year is just a multiple of four
        day_lim = month_length(m_raw[MONTH_W-1:0]);
        if (m_raw[MONTH_W-1:0] == MONTH_FEB && y_exp[1:0] == 2'b00)
        begin
            day_lim = FEB_LEAP_DAYS;
        end

        range_ok = (m_raw != '0) && (m_raw <= MONTH_MAX)
                   && (y_exp >= YEAR_MIN) && (y_exp <= YEAR_MAX)
                   && (d_raw != '0) && (d_raw <= ACC_W'(day_lim));

        complete = done_reg
                   || (field_idx_reg == FIELD_IDX_W'(NUM_FIELDS - 1) && digits_seen_reg);

        if (!any_seen_reg)
        begin
            fin_status = ST_EMPTY;
        end
        else if (failed_reg || !complete)
        begin
            fin_status = ST_SYNTAX;
        end
        else if (!range_ok)
        begin
            fin_status = ST_RANGE;
        end
        else
        begin
            fin_status = ST_VALID;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && is_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (dates.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg       <= ORDER_MDY;
            field_idx_reg   <= '0;
            digits_seen_reg <= 1'b0;
            done_reg        <= 1'b0;
            failed_reg      <= 1'b0;
            any_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            order_reg       <= order_next;
            field_idx_reg   <= field_idx_next;
            digits_seen_reg <= digits_seen_next;
            done_reg        <= done_next;
            failed_reg      <= failed_next;
            any_seen_reg    <= any_seen_next;
            out_valid_reg   <= out_valid_next;
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_end)
        begin
            out_status_reg <= fin_status;
            if (fin_status == ST_VALID)
            begin
                out_year_reg  <= y_exp[YEAR_W-1:0];
                out_month_reg <= m_raw[MONTH_W-1:0];
                out_day_reg   <= d_raw[DAY_W-1:0];
            end
            else
            begin
                out_year_reg  <= '0;
                out_month_reg <= '0;
                out_day_reg   <= '0;
            end
        end
    end

    assign dates.valid  = out_valid_reg;
    assign dates.status = out_status_reg;
    assign dates.year   = out_year_reg;
    assign dates.month  = out_month_reg;
    assign dates.day    = out_day_reg;

endmodule

### hdl/date_string_parse_validate.sv
// top level of the date string parser and validator
//
// takes a date string one character item per cycle on chars, a zero character
// closing the string, and for each closed string gives one result item on dates:
// a status (valid, syntax error, out of range, empty) and the year, month and day,
// which are zero unless the status is valid. the three numbers stand in the order
// set by field_order (month-day-year, day-month-year, year-month-day) and are
// separated by '/', '-' or the extra_separator character; two-digit years map to
// 1980-2079 style windows (80-99 to 19xx, 0-79 to 20xx) and the date must fall in
// 1980-2099. throughput is one character per cycle while the token queue is not
// full, the back end accumulating each digit as it takes it; a closing character
// goes through the token queue, then the result register holding its result item.
// the front end classifies characters into tokens, a two-entry queue decouples it
// from the back end, so a stalled dates channel only stops chars once the queue
// fills. configuration is written through cfg_we, cfg_index and cfg_data; the
// user must write it only while the block is idle, the block does not enforce it;
// index 0 is field_order, index 1 is extra_separator, others ignored
module date_string_parse_validate (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dspv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dspv_pkg::CFG_DATA_W-1:0]     cfg_data,
    dspv_char_if.sink                           chars,
    dspv_date_if.source                         dates
);
    import dspv_pkg::*;

    cfg_write_t cfg;
    // front to queue
    logic       push_valid;
    token_t     push_tok;
    logic       push_ready;
    // queue to back
    logic       pop_valid;
    token_t     pop_tok;
    logic       pop_ready;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // character classification, holds extra_separator
    dspv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .chars      (chars),
        .push_valid (push_valid),
        .push_tok   (push_tok),
        .push_ready (push_ready)
    );

    // decoupling queue
    dspv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_tok   (push_tok),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_tok    (pop_tok),
        .pop_ready  (pop_ready)
    );

    // parser, date check and result register, holds field_order
    dspv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tok_valid (pop_valid),
        .tok       (pop_tok),
        .tok_ready (pop_ready),
        .dates     (dates)
    );

`ifndef SYNTHESIS
    // an accepted character is in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.ready) |=> pop_valid)
        else $error("accepted item missing from token queue");

    // non-valid results carry a zero date
    assert property (@(posedge clk) disable iff (!rst_n)
        (dates.valid && dates.status != ST_VALID)
            |-> (dates.year == '0 && dates.month == '0 && dates.day == '0))
        else $error("nonzero date on failed result");

    // valid results stay inside the calendar window
    assert property (@(posedge clk) disable iff (!rst_n)
        (dates.valid && dates.status == ST_VALID)
            |-> (dates.month != '0 && dates.month <= 4'd12 && dates.day != '0
                 && dates.year >= 12'd1980 && dates.year <= 12'd2099))
        else $error("valid result outside calendar range");

    // a closing token is only taken when the result register can load
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready && pop_tok.kind == KIND_END) |=> dates.valid)
        else $error("end of string did not produce a result");
`endif

endmodule

### dv/tb_top.sv
// testbench for the date string parser: random date strings, predicted results, checked in order
module tb_top;
    import dspv_pkg::*;

    // cycles with no item moving on either channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // receiver hold-off long enough to fill the token queue and stall chars
    localparam int LONG_HOLD      = 120;
    // settle time before a register write or the final verdict
    localparam int DRAIN_CYCLES   = 4;
    // random characters queued per register setting
    localparam int PHASE_CHARS    = 100;

    // register indexes past the last real register, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    // the unused field order code, which must act as month-day-year
    localparam logic [ORDER_W-1:0]   ORDER_ALIAS  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } date_result_t;

    // ways to damage an otherwise well-formed date string
    typedef enum int unsigned {
        BREAK_NONE,
        BREAK_EARLY_END,
        BREAK_BAD_SEP,
        BREAK_NO_DIGITS
    } break_kind_e;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dspv_char_if char_ch();
    dspv_date_if date_ch();

    date_string_parse_validate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chars     (char_ch),
        .dates     (date_ch)
    );

    // characters waiting to be offered, and date results still owed by the block
    logic [CHAR_W-1:0] pending_chars[$];
    date_result_t      expected_dates[$];

    // predictor copy of the registers
    logic [ORDER_W-1:0] order_reg;
    logic [CHAR_W-1:0]  sep_reg;

    // predictor copy of the parse state
    logic [1:0]        field_idx;
    bit                have_digits;
    bit                third_done;
    bit                syntax_bad;
    bit                seen_any;
    logic [ACC_W-1:0]  acc [NUM_FIELDS];

    // handshake bookkeeping shared between the clocked blocks
    logic        char_fire;
    bit          steady;
    int          hold_req;
    int          hold_seen = 0;
    int          hold_left = 0;
    int unsigned quiet_cycles = 0;

    // run statistics
    int unsigned error_count = 0;
    int unsigned chars_taken = 0;
    int unsigned results_checked = 0;
    int unsigned status_count [4] = '{0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void restart_parse();
        field_idx   = '0;
        have_digits = 1'b0;
        third_done  = 1'b0;
        syntax_bad  = 1'b0;
        seen_any    = 1'b0;
        foreach (acc[i]) acc[i] = '0;
    endfunction

    // status and date for the string that a zero character closes
    function automatic date_result_t close_string();
        date_result_t r;
        int unsigned  y;
        int unsigned  m;
        int unsigned  d;
        int unsigned  lim;
        bit           leap;
        r = '0;
        if (!seen_any)
            r.status = ST_EMPTY;
        else if (syntax_bad || (!third_done && !(field_idx == 2 && have_digits)))
            // a syntax error, or the string ended before the third number had a digit
            r.status = ST_SYNTAX;
        else
        begin
            case (order_reg)
                ORDER_DMY:
                begin
                    d = acc[0];
                    m = acc[1];
                    y = acc[2];
                end
                ORDER_YMD:
                begin
                    y = acc[0];
                    m = acc[1];
                    d = acc[2];
                end
                default:
                begin
                    // month-day-year, also for the unused order code
                    m = acc[0];
                    d = acc[1];
                    y = acc[2];
                end
            endcase
            // two-digit years: 80-99 in the 1900s, 0-79 in the 2000s
            if (y <= SHORT_MAX)
                y = y + ((y >= SHORT_PIVOT) ? CENTURY_1900 : CENTURY_2000);
            if (m < 1 || m > MONTH_MAX || y < YEAR_MIN || y > YEAR_MAX)
                r.status = ST_RANGE;
            else
            begin
                leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
                case (m)
                    4, 6, 9, 11: lim = 30;
                    MONTH_FEB:   lim = leap ? FEB_LEAP_DAYS : 28;
                    default:     lim = 31;
                endcase
                if (d < 1 || d > lim)
                    r.status = ST_RANGE;
                else
                begin
                    r.status = ST_VALID;
                    r.year   = y[YEAR_W-1:0];
                    r.month  = m[MONTH_W-1:0];
                    r.day    = d[DAY_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // advance the parse by one accepted character
    function automatic void parse_char(input logic [CHAR_W-1:0] c);
        date_result_t r;
        if (c == CHAR_NUL)
        begin
            r = close_string();
            expected_dates.push_back(r);
            status_count[r.status]++;
            restart_parse();
        end
        else
        begin
            seen_any = 1'b1;
            // after a syntax error or the third number, everything up to the end is ignored
            if (!syntax_bad && !third_done)
            begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                begin
                    // digits win even when the extra separator is a digit; 16-bit wrap
                    acc[field_idx] = acc[field_idx] * 16'd10 + ACC_W'(c - CHAR_ZERO);
                    have_digits = 1'b1;
                end
                else if (!have_digits)
                    syntax_bad = 1'b1;
                else if (field_idx >= 2)
                    third_done = 1'b1;
                else if (c == CHAR_SLASH || c == CHAR_DASH || c == sep_reg)
                begin
                    field_idx   = field_idx + 1'b1;
                    have_digits = 1'b0;
                end
                else
                    syntax_bad = 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    // a string as written, closed by a zero character
    task automatic queue_text(input string s);
        foreach (s[i]) pending_chars.push_back(s[i]);
        pending_chars.push_back(CHAR_NUL);
    endtask

    // decimal digits of a value, now and then with leading zeros
    task automatic push_number(input int unsigned v);
        string digits;
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0)
            pending_chars.push_back(CHAR_ZERO);
        digits = $sformatf("%0d", v);
        foreach (digits[i]) pending_chars.push_back(digits[i]);
    endtask

    // one of the accepted separators; a zero extra separator would end the string
    function automatic logic [CHAR_W-1:0] pick_sep();
        int unsigned k;
        k = $urandom_range(0, 2);
        if (k == 2 && sep_reg != CHAR_NUL)
            return sep_reg;
        return k[0] ? CHAR_DASH : CHAR_SLASH;
    endfunction

    // a nonzero character that is neither a digit nor a separator
    function automatic logic [CHAR_W-1:0] pick_junk();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(1, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_SLASH || c == CHAR_DASH
               || c == sep_reg);
        return c;
    endfunction

    // mostly well-formed dates with random content, some broken ones, some noise
    task automatic queue_random_string();
        int unsigned shape;
        int unsigned m;
        int unsigned d;
        int unsigned y;
        int unsigned where;
        int unsigned vals [3];
        break_kind_e brk;
        shape = $urandom_range(0, 99);
        if (shape < 10)
        begin
            // noise: arbitrary nonzero bytes, possibly none
            repeat ($urandom_range(0, 6))
                pending_chars.push_back(CHAR_W'($urandom_range(1, 255)));
        end
        else
        begin
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 12);
            case ($urandom_range(0, 7))
                0, 1, 2, 3: d = $urandom_range(1, 28);
                4, 5:       d = $urandom_range(29, 31);
                6:          d = ($urandom_range(0, 1) == 0) ? 0 : 32;
                default:    d = $urandom_range(0, 99);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: y = $urandom_range(0, 99);
                4, 5, 6, 7: y = $urandom_range(1978, 2101);
                8:          y = $urandom_range(0, 999999);
                // wraps back into the valid window
                default:    y = 65536 + $urandom_range(1980, 2099);
            endcase
            case (order_reg)
                ORDER_DMY: vals = '{d, m, y};
                ORDER_YMD: vals = '{y, m, d};
                default:   vals = '{m, d, y};
            endcase
            brk   = (shape < 25) ? break_kind_e'($urandom_range(1, 3)) : BREAK_NONE;
            where = $urandom_range(0, 2);
            for (int i = 0; i < 3 && !(brk == BREAK_EARLY_END && i == where); i++)
            begin
                if (!(brk == BREAK_NO_DIGITS && i == where))
                    push_number(vals[i]);
                if (i < 2)
                    pending_chars.push_back((brk == BREAK_BAD_SEP && i == where) ?
                                            pick_junk() : pick_sep());
            end
            // trailing text after the third number
            if ($urandom_range(0, 4) == 0)
            begin
                pending_chars.push_back(pick_junk());
                repeat ($urandom_range(0, 3))
                    pending_chars.push_back(CHAR_W'($urandom_range(1, 255)));
            end
        end
        pending_chars.push_back(CHAR_NUL);
    endtask

    task automatic fill_random(input int unsigned n);
        int unsigned start;
        start = pending_chars.size();
        while (pending_chars.size() - start < n)
            queue_random_string();
    endtask

    // ------------------------------------------------------------------
    // register writes and idle detection
    // ------------------------------------------------------------------

    // wait until the block owes nothing, then let it settle
    task automatic wait_drained();
        while (pending_chars.size() != 0 || char_ch.valid || expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        // the block is idle, so the predictor can take the new value at once
        if (idx == REG_FIELD_ORDER)
            order_reg = val[ORDER_W-1:0];
        else if (idx == REG_EXTRA_SEP)
            sep_reg = val;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_checked, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // sender: offers the next character at the falling edge, idles now and then
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            char_ch.valid <= 1'b0;
        else if (!char_ch.valid || char_fire)
        begin
            // a held item moves on only once it was taken at the last rising edge
            if (pending_chars.size() != 0 && (steady || $urandom_range(0, 99) >= 7))
            begin
                char_ch.valid     <= 1'b1;
                char_ch.character <= pending_chars.pop_front();
            end
            else
                char_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready at the falling edge, random gaps plus an on-demand long hold
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            date_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            date_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen     <= hold_req;
            hold_left     <= LONG_HOLD;
            date_ch.ready <= 1'b0;
        end
        else
            date_ch.ready <= steady || ($urandom_range(0, 99) >= 7);
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        date_result_t got;
        date_result_t want;
        char_fire <= rst_n && char_ch.valid && char_ch.ready;
        if (rst_n)
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                parse_char(char_ch.character);
                chars_taken++;
            end
            if (date_ch.valid && date_ch.ready)
            begin
                got.status = date_ch.status;
                got.year   = date_ch.year;
                got.month  = date_ch.month;
                got.day    = date_ch.day;
                if (expected_dates.size() == 0)
                    report_mismatch("result with no string closed, status", got.status, 0);
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.year !== want.year)
                        report_mismatch("year", got.year, want.year);
                    if (got.month !== want.month)
                        report_mismatch("month", got.month, want.month);
                    if (got.day !== want.day)
                        report_mismatch("day", got.day, want.day);
                    results_checked++;
                end
            end
            // hang detection: any movement on either channel restarts the count
            if ((char_ch.valid && char_ch.ready) || (date_ch.valid && date_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_FIELD_ORDER;
        cfg_data          = '0;
        char_ch.valid     = 1'b0;
        char_ch.character = CHAR_NUL;
        date_ch.ready     = 1'b0;
        char_fire         = 1'b0;
        steady            = 1'b0;
        hold_req          = 0;
        order_reg         = ORDER_MDY;
        sep_reg           = EXTRA_SEP_RESET;
        restart_parse();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: month-day-year, dot as extra separator
        queue_text("");              // empty string
        queue_text("/");             // number with no digits
        queue_text("1x");            // wrong separator
        queue_text("1/2");           // string ends inside the second number
        queue_text("2/29/0");        // leap day, two-digit year into the 2000s
        queue_text("13/1/80\3775");  // month out of range, then trailing 0xff and a digit
        fill_random(PHASE_CHARS);
        wait_drained();

        // day-month-year, top extra separator; the receiver goes quiet for a while
        write_reg(REG_FIELD_ORDER, ORDER_DMY);
        write_reg(REG_EXTRA_SEP, 8'hFF);
        fill_random(PHASE_CHARS);
        hold_req = hold_req + 1;
        wait_drained();

        // year-month-day, extra separator zero: an early end is still a syntax error
        write_reg(REG_FIELD_ORDER, ORDER_YMD);
        write_reg(REG_EXTRA_SEP, CHAR_NUL);
        queue_text("2000-2");
        fill_random(PHASE_CHARS);
        wait_drained();

        // spare indexes must change nothing; unused order code; a digit as separator
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'hFF);
        write_reg(REG_FIELD_ORDER, ORDER_ALIAS);
        write_reg(REG_EXTRA_SEP, CHAR_ZERO + 8'd5);
        fill_random(PHASE_CHARS);
        wait_drained();

        // back to month-day-year, random separator, no idling on either side
        write_reg(REG_FIELD_ORDER, ORDER_MDY);
        write_reg(REG_EXTRA_SEP, CHAR_W'($urandom_range(1, 255)));
        steady = 1'b1;
        fill_random(PHASE_CHARS);
        wait_drained();
        steady = 1'b0;

        if (expected_dates.size() != 0)
            report_mismatch("results never delivered", 0, expected_dates.size());
        $display("run covered %0d characters and %0d date results over five register settings",
                 chars_taken, results_checked);
        $display("results: %0d valid, %0d syntax error, %0d out of range, %0d empty",
                 status_count[ST_VALID], status_count[ST_SYNTAX], status_count[ST_RANGE],
                 status_count[ST_EMPTY]);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/dspv_pkg.sv
hdl/dspv_if.sv
hdl/dspv_front.sv
hdl/dspv_queue.sv
hdl/dspv_back.sv
hdl/date_string_parse_validate.sv
dv/tb_top.sv
